// ===== src/mhsl_pkg.sv =====
`timescale 1ns / 1ps

package mhsl_pkg;

  // Fixed point fractions: FB fraction bits, FW bits hold the value one itself
  localparam int FB = 16;
  localparam int FW = FB + 1;

  localparam logic [FW-1:0] ONE        = FW'(64'd1 << FB);
  localparam logic [FW-1:0] HALF       = FW'((64'd1 << FB) / 2);
  localparam logic [FW-1:0] THIRD      = FW'(((64'd1 << FB) + 1) / 3);
  localparam logic [FW-1:0] TWO_THIRDS = FW'((2 * (64'd1 << FB) + 1) / 3);
  localparam logic [FW-1:0] SIXTH      = FW'(((64'd1 << FB) + 3) / 6);

  // Lightness: round(num * ONE / 130050) by reciprocal multiply and correction
  localparam int NUM_W = 17;
  localparam int LK    = 18;
  localparam int RW    = FB + 2;
  localparam int PW    = NUM_W + RW;
  localparam int XW    = NUM_W + FB;
  localparam logic [NUM_W-1:0] LUM_DIV  = NUM_W'(130050);
  localparam logic [NUM_W-1:0] LUM_HALF = NUM_W'(65025);
  localparam logic [RW-1:0]    LUM_R    = RW'((64'd1 << (FB + LK)) / 64'd130050);

  // Serial divider for tint saturation and hue
  localparam int DW    = FB + 11;
  localparam int DVS_W = 11;
  localparam int CNT_W = $clog2(DW);

  // Pixel pipeline depth
  localparam int NSTG = 9;

  // Register indexes
  localparam logic [1:0] REG_TINT_RED   = 2'd0;
  localparam logic [1:0] REG_TINT_GREEN = 2'd1;
  localparam logic [1:0] REG_TINT_BLUE  = 2'd2;

  typedef struct packed {
    logic [8:0]    st;
    logic [FW-1:0] sat;
    logic [FB-1:0] t_red;
    logic [FB-1:0] t_green;
    logic [FB-1:0] t_blue;
  } tint_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       masked;
  } side_t;

  // round(255 * c / ONE), c at most ONE
  function automatic logic [7:0] to_byte(input logic [FW-1:0] c);
    logic [FW+8:0] s;
    logic [FW+8:0] sh;
    begin
      s  = ({c, 8'd0} - (FW + 9)'(c)) + (FW + 9)'(HALF);
      sh = s >> FB;
      to_byte = (sh > (FW + 9)'(255)) ? 8'd255 : sh[7:0];
    end
  endfunction

endpackage

// ===== src/mhsl_tint.sv =====
`timescale 1ns / 1ps

module mhsl_tint (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  output mhsl_pkg::tint_t       tint_o,
  output logic                  busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SAT  = 4'b0100,
    ST_HUE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] tr_q, tg_q, tb_q;
  mhsl_pkg::tint_t tint_q;

  logic [mhsl_pkg::DW-1:0]    dvd_q;
  logic [mhsl_pkg::DVS_W-1:0] dvs_q;
  logic [mhsl_pkg::DVS_W-1:0] rem_q;
  logic [mhsl_pkg::FW-1:0]    quot_q;
  logic [mhsl_pkg::CNT_W-1:0] cnt_q;

  // Tint max/min, difference and sum
  logic [7:0]  mx, mn, d;
  logic [8:0]  st, den;
  logic [10:0] d6;
  logic signed [11:0] n_s;
  logic [mhsl_pkg::DW-1:0] sat_dvd, hue_dvd;

  always_comb begin
    mx = tr_q;
    if (tg_q > mx) mx = tg_q;
    if (tb_q > mx) mx = tb_q;
    mn = tr_q;
    if (tg_q < mn) mn = tg_q;
    if (tb_q < mn) mn = tb_q;
    d   = mx - mn;
    st  = {1'b0, mx} + {1'b0, mn};
    den = (st > 9'd255) ? (9'd510 - st) : st;
    d6  = ({3'b0, d} << 2) + ({3'b0, d} << 1);
    // hue sector numerator in sixths of d
    if (mx == tr_q) begin
      n_s = $signed({4'b0, tg_q}) - $signed({4'b0, tb_q});
      if (tg_q < tb_q) n_s = n_s + $signed({1'b0, d6});
    end else if (mx == tg_q) begin
      n_s = $signed({4'b0, tb_q}) - $signed({4'b0, tr_q}) + $signed({3'b0, d, 1'b0});
    end else begin
      n_s = $signed({4'b0, tr_q}) - $signed({4'b0, tg_q}) + $signed({2'b0, d, 2'b0});
    end
    sat_dvd = (mhsl_pkg::DW'(d) << mhsl_pkg::FB) + mhsl_pkg::DW'(den >> 1);
    hue_dvd = (mhsl_pkg::DW'(n_s[10:0]) << mhsl_pkg::FB)
              + mhsl_pkg::DW'(({2'b0, d} << 1) + {2'b0, d});
  end

  // One restoring step a cycle
  logic [mhsl_pkg::DVS_W:0]   rem_sh;
  logic                       ge;
  logic [mhsl_pkg::DVS_W-1:0] rem_nx;
  logic [mhsl_pkg::FW-1:0]    q_fin;
  logic                       last;

  always_comb begin
    rem_sh = {rem_q, dvd_q[mhsl_pkg::DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? mhsl_pkg::DVS_W'(rem_sh - {1'b0, dvs_q}) : mhsl_pkg::DVS_W'(rem_sh);
    q_fin  = {quot_q[mhsl_pkg::FW-2:0], ge};
    last   = cnt_q == mhsl_pkg::CNT_W'(mhsl_pkg::DW - 1);
  end

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = ST_LOAD;
    end else begin
      unique case (state_q)
        ST_IDLE: state_d = ST_IDLE;
        ST_LOAD: state_d = (d == 8'd0) ? ST_IDLE : ST_SAT;
        ST_SAT:  state_d = last ? ST_HUE : ST_SAT;
        ST_HUE:  state_d = last ? ST_IDLE : ST_HUE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // Control state and tint results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tr_q           <= '0;
      tg_q           <= '0;
      tb_q           <= '0;
      cnt_q          <= '0;
      tint_q.st      <= '0;
      tint_q.sat     <= '0;
      tint_q.t_green <= '0;
      tint_q.t_red   <= mhsl_pkg::FB'(mhsl_pkg::THIRD);
      tint_q.t_blue  <= mhsl_pkg::FB'(mhsl_pkg::ONE - mhsl_pkg::THIRD);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mhsl_pkg::REG_TINT_RED:   tr_q <= cfg_data_i;
          mhsl_pkg::REG_TINT_GREEN: tg_q <= cfg_data_i;
          mhsl_pkg::REG_TINT_BLUE:  tb_q <= cfg_data_i;
          default: ;
        endcase
      end else begin
        unique case (state_q)
          ST_LOAD: begin
            tint_q.st <= st;
            cnt_q     <= '0;
            if (d == 8'd0) begin
              tint_q.sat     <= '0;
              tint_q.t_green <= '0;
              tint_q.t_red   <= mhsl_pkg::FB'(mhsl_pkg::THIRD);
              tint_q.t_blue  <= mhsl_pkg::FB'(mhsl_pkg::ONE - mhsl_pkg::THIRD);
            end
          end
          ST_SAT: begin
            cnt_q <= last ? '0 : cnt_q + 1'b1;
            if (last) tint_q.sat <= q_fin;
          end
          ST_HUE: begin
            cnt_q <= last ? '0 : cnt_q + 1'b1;
            if (last) begin
              tint_q.t_green <= q_fin[mhsl_pkg::FB-1:0];
              tint_q.t_red   <= mhsl_pkg::FB'({1'b0, q_fin[mhsl_pkg::FB-1:0]}
                                              + mhsl_pkg::THIRD);
              tint_q.t_blue  <= mhsl_pkg::FB'({1'b0, q_fin[mhsl_pkg::FB-1:0]}
                                              + mhsl_pkg::ONE - mhsl_pkg::THIRD);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      dvd_q  <= sat_dvd;
      dvs_q  <= mhsl_pkg::DVS_W'(den);
      rem_q  <= '0;
      quot_q <= '0;
    end else if (state_q == ST_SAT && last) begin
      dvd_q  <= hue_dvd;
      dvs_q  <= d6;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= rem_nx;
      quot_q <= q_fin;
    end
  end

  assign tint_o = tint_q;
  assign busy_o = state_q != ST_IDLE;

endmodule

// ===== src/mhsl_lum.sv =====
`timescale 1ns / 1ps

module mhsl_lum (
  input  logic                        clk_i,
  input  logic [mhsl_pkg::NSTG:1]     en_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic [8:0]                  st_i,
  output logic [mhsl_pkg::FW-1:0]     lum_o
);

  logic [mhsl_pkg::NUM_W-1:0] num1_q, num2_q, num3_q;
  logic [mhsl_pkg::PW-1:0]    prod2_q;
  logic [mhsl_pkg::FW-1:0]    q03_q, lum4_q;
  logic [mhsl_pkg::XW-1:0]    m3_q;

  // Stage 1: blended lightness numerator
  logic [7:0] mx, mn;
  logic [8:0] sb;
  logic [mhsl_pkg::NUM_W-1:0] num_d;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    sb = {1'b0, mx} + {1'b0, mn};
    if (st_i > 9'd255) begin
      num_d = ({sb, 8'd0} - mhsl_pkg::NUM_W'(sb))
              + mhsl_pkg::NUM_W'(mhsl_pkg::NUM_W'(9'd510 - sb)
                                 * mhsl_pkg::NUM_W'(st_i - 9'd255));
    end else begin
      num_d = mhsl_pkg::NUM_W'(sb) * mhsl_pkg::NUM_W'(st_i);
    end
  end

  // Stage 4: correct the reciprocal estimate by up to two
  logic [mhsl_pkg::XW-1:0] x4, r4;
  logic [mhsl_pkg::FW:0]   lum_d;

  always_comb begin
    x4 = (mhsl_pkg::XW'(num3_q) << mhsl_pkg::FB) + mhsl_pkg::XW'(mhsl_pkg::LUM_HALF);
    r4 = x4 - m3_q;
    lum_d = {1'b0, q03_q};
    if (r4 >= (mhsl_pkg::XW'(mhsl_pkg::LUM_DIV) << 1)) lum_d = lum_d + 2'd2;
    else if (r4 >= mhsl_pkg::XW'(mhsl_pkg::LUM_DIV)) lum_d = lum_d + 2'd1;
    if (lum_d > {1'b0, mhsl_pkg::ONE}) lum_d = {1'b0, mhsl_pkg::ONE};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) num1_q <= num_d;
    if (en_i[2]) begin
      num2_q  <= num1_q;
      prod2_q <= mhsl_pkg::PW'(num1_q) * mhsl_pkg::PW'(mhsl_pkg::LUM_R);
    end
    if (en_i[3]) begin
      num3_q <= num2_q;
      q03_q  <= mhsl_pkg::FW'(prod2_q >> mhsl_pkg::LK);
      m3_q   <= mhsl_pkg::XW'(mhsl_pkg::FW'(prod2_q >> mhsl_pkg::LK))
                * mhsl_pkg::XW'(mhsl_pkg::LUM_DIV);
    end
    if (en_i[4]) lum4_q <= mhsl_pkg::FW'(lum_d);
  end

  assign lum_o = lum4_q;

endmodule

// ===== src/mhsl_chan.sv =====
`timescale 1ns / 1ps

module mhsl_chan (
  input  logic                        clk_i,
  input  logic [mhsl_pkg::NSTG:1]     en_i,
  input  logic [mhsl_pkg::FW-1:0]     p_i,
  input  logic [mhsl_pkg::FW-1:0]     q_i,
  input  logic [mhsl_pkg::FB-1:0]     t_i,
  output logic [mhsl_pkg::FW-1:0]     v_o
);

  typedef enum logic [1:0] {
    SEL_RAMP = 2'd0,
    SEL_Q    = 2'd1,
    SEL_P    = 2'd2
  } sel_e;

  sel_e                        sel7_q, sel_d;
  logic [mhsl_pkg::FW-1:0]     p7_q, q7_q, v8_q;
  logic [2*mhsl_pkg::FW-1:0]   prod7_q;

  // Stage 7: pick the hue segment and the ramp factor
  logic [mhsl_pkg::FW-1:0] tt, x, f;
  logic [mhsl_pkg::FW+1:0] six;

  always_comb begin
    tt    = {1'b0, t_i};
    x     = '0;
    sel_d = SEL_P;
    if (tt < mhsl_pkg::SIXTH) begin
      sel_d = SEL_RAMP;
      x     = tt;
    end else if (tt < mhsl_pkg::HALF) begin
      sel_d = SEL_Q;
    end else if (tt < mhsl_pkg::TWO_THIRDS) begin
      sel_d = SEL_RAMP;
      x     = mhsl_pkg::TWO_THIRDS - tt;
    end
    six = {x, 1'b0, 1'b0} + {1'b0, x, 1'b0};
    f   = mhsl_pkg::FW'(six);
  end

  // Stage 8: channel fraction
  logic [mhsl_pkg::FW:0]     ramp;
  logic [2*mhsl_pkg::FW-1:0] rnd;
  logic [mhsl_pkg::FW-1:0]   v_d;

  always_comb begin
    rnd  = (prod7_q + (2 * mhsl_pkg::FW)'(mhsl_pkg::HALF)) >> mhsl_pkg::FB;
    ramp = {1'b0, p7_q} + (mhsl_pkg::FW + 1)'(rnd);
    if (ramp > {1'b0, mhsl_pkg::ONE}) ramp = {1'b0, mhsl_pkg::ONE};
    unique case (sel7_q)
      SEL_RAMP: v_d = mhsl_pkg::FW'(ramp);
      SEL_Q:    v_d = q7_q;
      SEL_P:    v_d = p7_q;
      default:  v_d = p7_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      sel7_q  <= sel_d;
      p7_q    <= p_i;
      q7_q    <= q_i;
      prod7_q <= (2 * mhsl_pkg::FW)'(q_i - p_i) * (2 * mhsl_pkg::FW)'(f);
    end
    if (en_i[8]) v8_q <= v_d;
  end

  assign v_o = v8_q;

endmodule

// ===== src/masked_hsl_tint_pixel_unit.sv =====
`timescale 1ns / 1ps

// Masked HSL tint: recolors RGBA pixels with the tint color's hue and
// saturation, keeping a lightness blended from the pixel and the tint.
// Input channel: in_valid_i / in_stall_o with base RGBA and mask alpha.
// A zero mask alpha passes the pixel through unchanged.
// Output channel: out_valid_o / out_stall_i with the result RGBA.
// A request passes through the stage registers to out_valid_o. While in_stall_o
// is low one pixel can enter every cycle, so throughput is one pixel per clock.
// Each of the 9 stages has its own valid bit and advances when the stage
// after it is empty or moving, so bubbles close up while the receiver stalls
// and a new request is still taken as long as some stage is free.
// Tint registers are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// After each write the tint saturation and hue are recomputed by a serial
// divider (not run for a gray tint); in_stall_o is high during that time.
// Reset clears the tint to black and the pipeline to empty; the divider is
// idle after reset.
module masked_hsl_tint_pixel_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] base_red_i,
  input  logic [7:0] base_green_i,
  input  logic [7:0] base_blue_i,
  input  logic [7:0] base_alpha_i,
  input  logic [7:0] mask_alpha_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  localparam int NS = mhsl_pkg::NSTG;
  localparam int FW = mhsl_pkg::FW;

  mhsl_pkg::tint_t tint;
  logic            tint_busy;

  logic [NS:1]   vld_q;
  logic [NS+1:1] rdy;
  logic          in_acc;

  mhsl_pkg::side_t side_q [NS-1:1];
  mhsl_pkg::side_t side_in;

  logic [FW-1:0]   lum4, lum5_q, p6_q, q6_q;
  logic [2*FW-1:0] lsp5_q;
  logic [FW-1:0]   v_red, v_green, v_blue;
  logic [7:0]      out_red_q, out_green_q, out_blue_q, out_alpha_q;

  mhsl_tint u_tint (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tint_o     (tint),
    .busy_o     (tint_busy)
  );

  // Stage readiness, from the output back to the input
  always_comb begin
    rdy[NS+1] = !out_stall_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1] || tint_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= in_acc;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Pass-through side data travels with each request
  always_comb begin
    side_in.red    = base_red_i;
    side_in.green  = base_green_i;
    side_in.blue   = base_blue_i;
    side_in.alpha  = base_alpha_i;
    side_in.masked = mask_alpha_i != 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) side_q[1] <= side_in;
    for (int k = 2; k <= NS - 1; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  mhsl_lum u_lum (
    .clk_i   (clk_i),
    .en_i    (rdy[NS:1]),
    .red_i   (base_red_i),
    .green_i (base_green_i),
    .blue_i  (base_blue_i),
    .st_i    (tint.st),
    .lum_o   (lum4)
  );

  // Stage 6: q and p of the HSL conversion
  logic [2*FW-1:0] ls_w;
  logic [FW-1:0]   ls;
  logic [FW:0]     q_raw, lum2;
  logic [FW-1:0]   q_d, p_d;

  always_comb begin
    ls_w = (lsp5_q + (2 * FW)'(mhsl_pkg::HALF)) >> mhsl_pkg::FB;
    ls   = FW'(ls_w);
    if (lum5_q < mhsl_pkg::HALF) q_raw = {1'b0, lum5_q} + {1'b0, ls};
    else q_raw = ({1'b0, lum5_q} + {1'b0, tint.sat}) - {1'b0, ls};
    if (q_raw > {1'b0, mhsl_pkg::ONE}) q_raw = {1'b0, mhsl_pkg::ONE};
    q_d  = FW'(q_raw);
    lum2 = {lum5_q, 1'b0};
    if (lum2 < {1'b0, q_d}) p_d = '0;
    else if ((lum2 - {1'b0, q_d}) > {1'b0, mhsl_pkg::ONE}) p_d = mhsl_pkg::ONE;
    else p_d = FW'(lum2 - {1'b0, q_d});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      lum5_q <= lum4;
      lsp5_q <= (2 * FW)'(lum4) * (2 * FW)'(tint.sat);
    end
    if (rdy[6]) begin
      q6_q <= q_d;
      p6_q <= p_d;
    end
  end

  mhsl_chan u_chan_red (
    .clk_i (clk_i),
    .en_i  (rdy[NS:1]),
    .p_i   (p6_q),
    .q_i   (q6_q),
    .t_i   (tint.t_red),
    .v_o   (v_red)
  );

  mhsl_chan u_chan_green (
    .clk_i (clk_i),
    .en_i  (rdy[NS:1]),
    .p_i   (p6_q),
    .q_i   (q6_q),
    .t_i   (tint.t_green),
    .v_o   (v_green)
  );

  mhsl_chan u_chan_blue (
    .clk_i (clk_i),
    .en_i  (rdy[NS:1]),
    .p_i   (p6_q),
    .q_i   (q6_q),
    .t_i   (tint.t_blue),
    .v_o   (v_blue)
  );

  // Stage 9: bytes and mask select into the output register
  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      out_alpha_q <= side_q[8].alpha;
      if (side_q[8].masked) begin
        out_red_q   <= mhsl_pkg::to_byte(v_red);
        out_green_q <= mhsl_pkg::to_byte(v_green);
        out_blue_q  <= mhsl_pkg::to_byte(v_blue);
      end else begin
        out_red_q   <= side_q[8].red;
        out_green_q <= side_q[8].green;
        out_blue_q  <= side_q[8].blue;
      end
    end
  end

  assign out_valid_o = vld_q[NS];
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign out_alpha_o = out_alpha_q;

`ifndef ASSERT_OFF
  // A register write holds off requests while the tint is recomputed
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o) else $error("request accepted right after tint write");

  // At most one request enters the pipeline per cycle
  a_fill_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) <= $past($countones(vld_q)) + 1))
    else $error("pipeline occupancy grew by more than one");

  // Tint saturation never exceeds one
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tint.sat <= mhsl_pkg::ONE) else $error("tint saturation out of range");
`endif

endmodule

// ===== sim/tb_masked_hsl_tint_pixel_unit.sv =====
`timescale 1ns / 1ps

module tb_masked_hsl_tint_pixel_unit;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = mhsl_pkg::NSTG + 8;
  localparam longint FX_ONE = longint'(1) << mhsl_pkg::FB;
  localparam longint FX_HALF = FX_ONE / 2;
  localparam longint FX_THIRD = (FX_ONE + 1) / 3;
  localparam longint FX_TWO_THIRDS = (2 * FX_ONE + 1) / 3;
  localparam longint FX_SIXTH = (FX_ONE + 3) / 6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] base_red_i = '0;
  logic [7:0] base_green_i = '0;
  logic [7:0] base_blue_i = '0;
  logic [7:0] base_alpha_i = '0;
  logic [7:0] mask_alpha_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic [7:0] out_alpha_o;

  masked_hsl_tint_pixel_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tint shadow and pending expected pixels
  logic [7:0] tint_r = '0, tint_g = '0, tint_b = '0;
  rgba_t      expected_pixels[$];
  int         mismatches = 0;
  int         pixels_sent = 0;
  int         pixels_checked = 0;
  int         masked_sent = 0;
  int         tint_settings = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  function automatic longint rdiv(longint a, longint b);
    return (a + b / 2) / b;
  endfunction

  function automatic longint clampf(longint v);
    if (v < 0) return 0;
    if (v > FX_ONE) return FX_ONE;
    return v;
  endfunction

  function automatic logic [7:0] frac_to_byte(longint c);
    longint b;
    b = rdiv(255 * clampf(c), FX_ONE);
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic longint hsl_channel(longint p, longint q, longint t);
    longint v;
    t = t % FX_ONE;
    if (t < 0) t += FX_ONE;
    if (t < FX_SIXTH) v = p + rdiv((q - p) * 6 * t, FX_ONE);
    else if (t < FX_HALF) v = q;
    else if (t < FX_TWO_THIRDS) v = p + rdiv((q - p) * 6 * (FX_TWO_THIRDS - t), FX_ONE);
    else v = p;
    return clampf(v);
  endfunction

  // recolor one pixel with the current tint
  function automatic rgba_t tint_pixel(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                                       logic [7:0] ba, logic [7:0] ma);
    longint r, g, b, tr, tg, tb, tmax, tmin, d, st, sb, sat, hue, num, lum, ls, q, p, n;
    rgba_t res;
    r = br; g = bg; b = bb; tr = tint_r; tg = tint_g; tb = tint_b;
    res.alpha = ba;
    if (ma == 0) begin
      res.red = br; res.green = bg; res.blue = bb;
      return res;
    end
    tmax = tr; if (tg > tmax) tmax = tg; if (tb > tmax) tmax = tb;
    tmin = tr; if (tg < tmin) tmin = tg; if (tb < tmin) tmin = tb;
    d = tmax - tmin;
    st = tmax + tmin;
    sat = 0;
    hue = 0;
    if (d != 0) begin
      sat = rdiv(d * FX_ONE, st > 255 ? 510 - st : st);
      if (tmax == tr) n = (tg - tb) + (tg < tb ? 6 * d : 0);
      else if (tmax == tg) n = (tb - tr) + 2 * d;
      else n = (tr - tg) + 4 * d;
      hue = rdiv(n * FX_ONE, 6 * d) % FX_ONE;
    end
    tmax = r; if (g > tmax) tmax = g; if (b > tmax) tmax = b;
    tmin = r; if (g < tmin) tmin = g; if (b < tmin) tmin = b;
    sb = tmax + tmin;
    num = (st > 255) ? sb * 255 + (510 - sb) * (st - 255) : sb * st;
    lum = clampf(rdiv(num * FX_ONE, 130050));
    if (sat == 0) begin
      res.red = frac_to_byte(lum);
      res.green = res.red;
      res.blue = res.red;
      return res;
    end
    ls = rdiv(lum * sat, FX_ONE);
    q = clampf(lum < FX_HALF ? lum + ls : lum + sat - ls);
    p = clampf(2 * lum - q);
    res.red = frac_to_byte(hsl_channel(p, q, hue + FX_THIRD));
    res.green = frac_to_byte(hsl_channel(p, q, hue));
    res.blue = frac_to_byte(hsl_channel(p, q, hue - FX_THIRD));
    return res;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(1, 3);
      3: return $urandom_range(8, 30);
      default: return 0;
    endcase
  endfunction

  // send one pixel request and record its expected result on acceptance
  task automatic send_pixel(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                            logic [7:0] ba, logic [7:0] ma);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    base_red_i = br; base_green_i = bg; base_blue_i = bb;
    base_alpha_i = ba; mask_alpha_i = ma;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(tint_pixel(br, bg, bb, ba, ma));
    pixels_sent++;
    if (ma != 0) masked_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
  endtask

  // wait until the pipeline has drained
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      mhsl_pkg::REG_TINT_RED:   tint_r = val;
      mhsl_pkg::REG_TINT_GREEN: tint_g = val;
      mhsl_pkg::REG_TINT_BLUE:  tint_b = val;
      default: ;
    endcase
  endtask

  task automatic set_tint(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    wait_idle();
    write_reg(mhsl_pkg::REG_TINT_RED, r);
    write_reg(mhsl_pkg::REG_TINT_GREEN, g);
    write_reg(mhsl_pkg::REG_TINT_BLUE, b);
    tint_settings++;
  endtask

  // reset tint is black; unmasked pixels pass through, masked ones are recolored
  task automatic test_pass_through();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00);
    send_pixel(8'h12, 8'hab, 8'h7f, 8'h80, 8'h01);
    set_tint(8'h40, 8'hc0, 8'h10);
    send_pixel(8'hff, 8'h00, 8'h55, 8'haa, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
  endtask

  // extreme tints, every hue sector, gray tints
  task automatic test_tint_extremes();
    logic [23:0] tints[10];
    tints = '{24'hff0000, 24'h00ff00, 24'h0000ff, 24'hff00ff, 24'hffffff,
              24'h808080, 24'h000000, 24'h10ff80, 24'hfe01ff, 24'h7f8080};
    foreach (tints[i]) begin
      set_tint(tints[i][23:16], tints[i][15:8], tints[i][7:0]);
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
      send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h80);
    end
  endtask

  // writes to the unmapped index leave the tint alone
  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_SPARE, 8'hff);
    send_pixel(8'h30, 8'h90, 8'he0, 8'h11, 8'h01);
  endtask

  task automatic test_random_pixels();
    for (int s = 0; s < 12; s++) begin
      case (s)
        0: set_tint(8'hff, 8'hff, 8'h00);
        1: set_tint(8'h00, 8'h01, 8'h00);
        default: set_tint(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      no_idle = (s == 2);
      for (int i = 0; i < 90; i++) send_random_pixel();
    end
    no_idle = 1'b0;
  endtask

  // receiver stalls: mostly short, a few long, with quiet stretches
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          out_stall_i <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end
        3: begin
          out_stall_i <= 1'b1;
          stall_left = $urandom_range(8, 30);
        end
        4: begin
          out_stall_i <= 1'b0;
          stall_left = $urandom_range(20, 60);
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h %h %h %h", out_red_o, out_green_o,
                   out_blue_o, out_alpha_o);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want != {out_red_o, out_green_o, out_blue_o, out_alpha_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: pixel %0d expected rgba %h %h %h %h got %h %h %h %h",
                     pixels_checked, want.red, want.green, want.blue, want.alpha,
                     out_red_o, out_green_o, out_blue_o, out_alpha_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL masked_hsl_tint_pixel_unit");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_pass_through();
    test_tint_extremes();
    test_spare_index();
    test_random_pixels();
    wait_idle();
    $display("sent %0d pixels (%0d masked) over %0d tint settings, checked %0d",
             pixels_sent, masked_sent, tint_settings, pixels_checked);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS masked_hsl_tint_pixel_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL masked_hsl_tint_pixel_unit");
    end
    $finish;
  end

endmodule
